// ===== sv/dfs_maze_carver_top_defines.svh =====
// Assertion macros for the maze carver top level.
// Included by dfs_maze_carver_top.sv; expects clk and rst_n in scope.
`ifndef DFS_MAZE_CARVER_TOP_DEFINES_SVH
`define DFS_MAZE_CARVER_TOP_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define DMC_ASSERT_HOLDS(name, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("dfs_maze_carver: invariant violated");

// A condition that must hold in the cycle after the antecedent.
`define DMC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dfs_maze_carver: next-cycle check failed");

`endif

// ===== sv/dmc_pkg.sv =====
// Shared types and constants for the maze carver.
// No dependencies; used by the interfaces and all modules.
`default_nettype none

package dmc_pkg;

    localparam int DIR_W    = 2;
    localparam int STATUS_W = 2;
    localparam int COORD_W  = 6;
    localparam int DEPTH_W  = 9;
    localparam int NUM_DIRS = 4;

    typedef enum logic [DIR_W-1:0] {
        DIR_RIGHT = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_UP    = 2'd2,
        DIR_DOWN  = 2'd3
    } dir_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_CARVED    = 2'd0,
        ST_BACKTRACK = 2'd1,
        ST_FINISHED  = 2'd2
    } status_t;

    typedef struct packed {
        status_t              status;
        logic [COORD_W-1:0]   cell_row;
        logic [COORD_W-1:0]   cell_col;
        logic [COORD_W-1:0]   wall_row;
        logic [COORD_W-1:0]   wall_col;
        logic [DEPTH_W-1:0]   stack_depth;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/dmc_in_if.sv =====
// Input channel of the maze carver: one item holds the direction order.
// Depends on dmc_pkg.
`default_nettype none

interface dmc_in_if import dmc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [DIR_W-1:0] try_first;
    logic [DIR_W-1:0] try_second;
    logic [DIR_W-1:0] try_third;
    logic [DIR_W-1:0] try_fourth;

    modport source (output valid, output try_first, output try_second,
                    output try_third, output try_fourth, input ready);
    modport sink   (input valid, input try_first, input try_second,
                    input try_third, input try_fourth, output ready);
endinterface

`default_nettype wire

// ===== sv/dmc_out_if.sv =====
// Result channel of the maze carver: one item per accepted input item.
// Depends on dmc_pkg.
`default_nettype none

interface dmc_out_if import dmc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [COORD_W-1:0]  cell_row;
    logic [COORD_W-1:0]  cell_col;
    logic [COORD_W-1:0]  wall_row;
    logic [COORD_W-1:0]  wall_col;
    logic [DEPTH_W-1:0]  stack_depth;

    modport source (output valid, output status, output cell_row, output cell_col,
                    output wall_row, output wall_col, output stack_depth, input ready);
    modport sink   (input valid, input status, input cell_row, input cell_col,
                    input wall_row, input wall_col, input stack_depth, output ready);
endinterface

`default_nettype wire

// ===== sv/dmc_visited.sv =====
// Visited map of the maze carver, one word per grid row, held in three
// row-organized memory copies (row above, same row, row below). Uses dmc_pkg.
`default_nettype none

module dmc_visited import dmc_pkg::*; #(
    parameter int CELLS_PER_SIDE = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 rd_en,
    input  logic [$clog2(CELLS_PER_SIDE)-1:0]    rd_row,
    input  logic                                 wr_en,
    input  logic [$clog2(CELLS_PER_SIDE)-1:0]    wr_row,
    input  logic [CELLS_PER_SIDE-1:0]            wr_word,
    output logic [CELLS_PER_SIDE-1:0]            up_word,
    output logic [CELLS_PER_SIDE-1:0]            mid_word,
    output logic [CELLS_PER_SIDE-1:0]            dn_word
);

    localparam int RW     = $clog2(CELLS_PER_SIDE);
    localparam int ROWS   = 2 ** RW;
    localparam int COPIES = 3;

    logic [ROWS-1:0]           row_valid_reg;
    logic [CELLS_PER_SIDE-1:0] fwd_word_reg;
    logic [RW-1:0]             rd_addr [COPIES];
    logic [CELLS_PER_SIDE-1:0] word [COPIES];

    assign rd_addr[0] = rd_row - RW'(1);
    assign rd_addr[1] = rd_row;
    assign rd_addr[2] = rd_row + RW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else if (wr_en)
        begin
            row_valid_reg[wr_row] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            fwd_word_reg <= wr_word;
        end
    end

    for (genvar g = 0; g < COPIES; g++)
    begin : g_copy
        logic [CELLS_PER_SIDE-1:0] mem [ROWS];
        logic [CELLS_PER_SIDE-1:0] data_reg;
        logic                      hit_reg;
        logic                      valid_reg;
        logic                      row0_reg;

        always_ff @(posedge clk)
        begin
            if (wr_en)
            begin
                mem[wr_row] <= wr_word;
            end
            if (rd_en)
            begin
                data_reg <= mem[rd_addr[g]];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                hit_reg   <= 1'b0;
                valid_reg <= 1'b0;
                row0_reg  <= 1'b0;
            end
            else if (rd_en)
            begin
                hit_reg   <= wr_en && (wr_row == rd_addr[g]);
                valid_reg <= row_valid_reg[rd_addr[g]];
                row0_reg  <= (rd_addr[g] == '0);
            end
        end

        // A row never written reads as its reset value: only the start cell set.
        always_comb
        begin
            priority if (hit_reg)
            begin
                word[g] = fwd_word_reg;
            end
            else if (valid_reg)
            begin
                word[g] = data_reg;
            end
            else if (row0_reg)
            begin
                word[g] = CELLS_PER_SIDE'(1);
            end
            else
            begin
                word[g] = '0;
            end
        end
    end

    assign up_word  = word[0];
    assign mid_word = word[1];
    assign dn_word  = word[2];

endmodule

`default_nettype wire

// ===== sv/dfs_maze_carver_top.sv =====
// Depth-first maze carver: path stack memory plus visited row memories.
// Depends on dmc_pkg, dmc_in_if, dmc_out_if, dmc_visited and the defines header.
//
//   channel   direction   item contents
//   step      in          try_first, try_second, try_third, try_fourth
//   result    out         status, cell_row, cell_col, wall_row, wall_col, stack_depth
//
// One item per cycle sustained unless the result stalls; a decided result is registered.
// The accept cycle reads the visited rows around the stack top and the stack entry below
// the top; the decision stage decides, writes back and computes the following stack top.
// A visited row written in the same cycle as it is read is forwarded.
// Reset is asynchronous and needs no clearing pass; a stalled result holds the next item.
`default_nettype none

module dfs_maze_carver_top import dmc_pkg::*; #(
    parameter int CELLS_PER_SIDE = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    dmc_in_if.sink    step,
    dmc_out_if.source result
);

    localparam int RW        = $clog2(CELLS_PER_SIDE);
    localparam int NUM_CELLS = CELLS_PER_SIDE * CELLS_PER_SIDE;
    localparam int AW        = $clog2(NUM_CELLS);
    localparam int SPW       = $clog2(NUM_CELLS + 1);

    localparam logic [RW-1:0]  LAST_IDX = RW'(CELLS_PER_SIDE - 1);
    localparam logic [SPW-1:0] SP_FULL  = SPW'(NUM_CELLS);

    logic                      step_accept;
    logic                      eval_fire;
    logic                      busy_reg;
    logic                      busy_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    result_t                   out_reg;
    result_t                   out_next;
    dir_t                      try_reg [NUM_DIRS];

    logic [RW-1:0]             top_row_reg;
    logic [RW-1:0]             top_row_next;
    logic [RW-1:0]             top_col_reg;
    logic [RW-1:0]             top_col_next;
    logic [SPW-1:0]            sp_reg;
    logic [SPW-1:0]            sp_next;

    logic [2*RW-1:0]           stack_mem [NUM_CELLS];
    logic [2*RW-1:0]           under_reg;
    logic [AW-1:0]             under_addr;
    logic                      stack_wr;

    logic [CELLS_PER_SIDE-1:0] up_word;
    logic [CELLS_PER_SIDE-1:0] mid_word;
    logic [CELLS_PER_SIDE-1:0] dn_word;
    logic [CELLS_PER_SIDE-1:0] pick_word;
    logic                      vis_wr_en;

    logic [RW-1:0]             nb_row [NUM_DIRS];
    logic [RW-1:0]             nb_col [NUM_DIRS];
    logic                      nb_ok [NUM_DIRS];
    logic                      found;
    dir_t                      pick;
    logic [RW-1:0]             pick_row;
    logic [RW-1:0]             pick_col;
    logic                      finished;
    logic                      carve;

    // Handshake and occupancy of the decision stage and the result register.
    assign eval_fire   = busy_reg && (!out_valid_reg || result.ready);
    assign step.ready  = !busy_reg || eval_fire;
    assign step_accept = step.valid && step.ready;

    assign busy_next      = step_accept || (busy_reg && !eval_fire);
    assign out_valid_next = eval_fire || (out_valid_reg && !result.ready);

    always_ff @(posedge clk)
    begin
        if (step_accept)
        begin
            try_reg[0] <= dir_t'(step.try_first);
            try_reg[1] <= dir_t'(step.try_second);
            try_reg[2] <= dir_t'(step.try_third);
            try_reg[3] <= dir_t'(step.try_fourth);
        end
    end

    // Neighbor candidates of the current stack top.
    always_comb
    begin
        nb_row[DIR_RIGHT] = top_row_reg;
        nb_col[DIR_RIGHT] = top_col_reg + RW'(1);
        nb_ok[DIR_RIGHT]  = (top_col_reg != LAST_IDX) && !mid_word[top_col_reg + RW'(1)];

        nb_row[DIR_LEFT]  = top_row_reg;
        nb_col[DIR_LEFT]  = top_col_reg - RW'(1);
        nb_ok[DIR_LEFT]   = (top_col_reg != '0) && !mid_word[top_col_reg - RW'(1)];

        nb_row[DIR_UP]    = top_row_reg - RW'(1);
        nb_col[DIR_UP]    = top_col_reg;
        nb_ok[DIR_UP]     = (top_row_reg != '0) && !up_word[top_col_reg];

        nb_row[DIR_DOWN]  = top_row_reg + RW'(1);
        nb_col[DIR_DOWN]  = top_col_reg;
        nb_ok[DIR_DOWN]   = (top_row_reg != LAST_IDX) && !dn_word[top_col_reg];
    end

    // The first direction in the given order that qualifies wins.
    always_comb
    begin
        found = 1'b0;
        pick  = DIR_RIGHT;
        for (int k = 0; k < NUM_DIRS; k++)
        begin
            if (!found && nb_ok[try_reg[k]])
            begin
                found = 1'b1;
                pick  = try_reg[k];
            end
        end
    end

    assign pick_row = nb_row[pick];
    assign pick_col = nb_col[pick];
    assign finished = (sp_reg == '0);
    assign carve    = !finished && found && (sp_reg != SP_FULL);

    always_comb
    begin
        unique case (pick)
            DIR_UP:    pick_word = up_word;
            DIR_DOWN:  pick_word = dn_word;
            DIR_RIGHT: pick_word = mid_word;
            DIR_LEFT:  pick_word = mid_word;
        endcase
    end

    assign vis_wr_en = eval_fire && carve;
    assign stack_wr  = eval_fire && carve;

    // Result of the step under decision.
    always_comb
    begin
        out_next = '0;
        priority if (finished)
        begin
            out_next.status = ST_FINISHED;
        end
        else if (carve)
        begin
            out_next.status      = ST_CARVED;
            out_next.cell_row    = COORD_W'({pick_row, 1'b1});
            out_next.cell_col    = COORD_W'({pick_col, 1'b1});
            out_next.wall_row    = COORD_W'(top_row_reg) + COORD_W'(pick_row) + COORD_W'(1);
            out_next.wall_col    = COORD_W'(top_col_reg) + COORD_W'(pick_col) + COORD_W'(1);
            out_next.stack_depth = DEPTH_W'(sp_reg + SPW'(1));
        end
        else
        begin
            out_next.status      = ST_BACKTRACK;
            out_next.cell_row    = COORD_W'({top_row_reg, 1'b1});
            out_next.cell_col    = COORD_W'({top_col_reg, 1'b1});
            out_next.stack_depth = DEPTH_W'(sp_reg - SPW'(1));
        end
    end

    // Stack top and pointer after the step; a pop exposes the entry read below the top.
    always_comb
    begin
        sp_next      = sp_reg;
        top_row_next = top_row_reg;
        top_col_next = top_col_reg;
        if (eval_fire && !finished)
        begin
            if (carve)
            begin
                sp_next      = sp_reg + SPW'(1);
                top_row_next = pick_row;
                top_col_next = pick_col;
            end
            else
            begin
                sp_next = sp_reg - SPW'(1);
                if (sp_reg == SPW'(2))
                begin
                    top_row_next = '0;
                    top_col_next = '0;
                end
                else
                begin
                    top_row_next = under_reg[2*RW-1:RW];
                    top_col_next = under_reg[RW-1:0];
                end
            end
        end
    end

    assign under_addr = AW'(sp_next - SPW'(2));

    always_ff @(posedge clk)
    begin
        if (stack_wr)
        begin
            stack_mem[sp_reg[AW-1:0]] <= {pick_row, pick_col};
        end
        if (step_accept)
        begin
            under_reg <= stack_mem[under_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            sp_reg        <= SPW'(1);
            top_row_reg   <= '0;
            top_col_reg   <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            sp_reg        <= sp_next;
            top_row_reg   <= top_row_next;
            top_col_reg   <= top_col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eval_fire)
        begin
            out_reg <= out_next;
        end
    end

    dmc_visited #(
        .CELLS_PER_SIDE(CELLS_PER_SIDE)
    ) u_visited (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (step_accept),
        .rd_row   (top_row_next),
        .wr_en    (vis_wr_en),
        .wr_row   (pick_row),
        .wr_word  (pick_word | (CELLS_PER_SIDE'(1) << pick_col)),
        .up_word  (up_word),
        .mid_word (mid_word),
        .dn_word  (dn_word)
    );

    assign result.valid       = out_valid_reg;
    assign result.status      = out_reg.status;
    assign result.cell_row    = out_reg.cell_row;
    assign result.cell_col    = out_reg.cell_col;
    assign result.wall_row    = out_reg.wall_row;
    assign result.wall_col    = out_reg.wall_col;
    assign result.stack_depth = out_reg.stack_depth;

`include "dfs_maze_carver_top_defines.svh"

    `DMC_ASSERT_HOLDS(a_sp_bound, sp_reg <= SP_FULL)
    `DMC_ASSERT_NEXT(a_depth_matches_sp, eval_fire, out_reg.stack_depth == DEPTH_W'(sp_reg))
    `DMC_ASSERT_NEXT(a_empty_stack_sticks, sp_reg == '0, sp_reg == '0)

endmodule

`default_nettype wire

// ===== test/tb_dfs_maze_carver_top.sv =====
// Testbench for dfs_maze_carver_top: walks a maze with directed and random direction orders,
// predicts every carve, backtrack and finished item, and compares each result field by field.
// Depends on dmc_pkg, dmc_in_if, dmc_out_if and the block itself.
`default_nettype none

module tb_dfs_maze_carver_top;
    import dmc_pkg::*;

    localparam int SIDE   = 16;
    localparam int NCELLS = SIDE * SIDE;
    localparam int RANDOM_ITEMS = 1600;
    localparam int PHASE_ITEMS  = 37;

    logic clk;
    logic rst_n;

    dmc_in_if  step_ch ();
    dmc_out_if result_ch ();

    dfs_maze_carver_top #(
        .CELLS_PER_SIDE(SIDE)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step_ch),
        .result (result_ch)
    );

    bit          seen_cell [NCELLS];
    int          trail [NCELLS];
    int unsigned trail_depth;

    result_t     expected_moves [$];
    int          send_idle_pct;
    int          recv_stall_pct;
    int          mismatches;
    int          results_seen;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic result_t carve_step(input dir_t d0, input dir_t d1,
                                           input dir_t d2, input dir_t d3);
        result_t res;
        dir_t    order [NUM_DIRS];
        int      r;
        int      c;
        int      nr;
        int      nc;
        int      hr;
        int      hc;
        int      top;
        int      k;
        bit      found;
        res = '0;
        order[0] = d0;
        order[1] = d1;
        order[2] = d2;
        order[3] = d3;
        if (trail_depth == 0 || trail_depth > NCELLS)
        begin
            res.status = ST_FINISHED;
            return res;
        end
        top = trail[trail_depth - 1] % NCELLS;
        r = top / SIDE;
        c = top % SIDE;
        found = 1'b0;
        hr = 0;
        hc = 0;
        for (k = 0; k < NUM_DIRS; k++)
        begin
            nr = r;
            nc = c;
            case (order[k])
                DIR_RIGHT: nc = c + 1;
                DIR_LEFT:  nc = c - 1;
                DIR_UP:    nr = r - 1;
                default:   nr = r + 1;
            endcase
            if (!found && nr >= 0 && nr < SIDE && nc >= 0 && nc < SIDE)
            begin
                if (!seen_cell[nr * SIDE + nc])
                begin
                    found = 1'b1;
                    hr = nr;
                    hc = nc;
                end
            end
        end
        if (found && trail_depth < NCELLS)
        begin
            seen_cell[hr * SIDE + hc] = 1'b1;
            trail[trail_depth] = hr * SIDE + hc;
            trail_depth++;
            res.status      = ST_CARVED;
            res.cell_row    = COORD_W'(2 * hr + 1);
            res.cell_col    = COORD_W'(2 * hc + 1);
            res.wall_row    = COORD_W'(r + hr + 1);
            res.wall_col    = COORD_W'(c + hc + 1);
            res.stack_depth = DEPTH_W'(trail_depth);
            return res;
        end
        trail_depth--;
        res.status      = ST_BACKTRACK;
        res.cell_row    = COORD_W'(2 * r + 1);
        res.cell_col    = COORD_W'(2 * c + 1);
        res.stack_depth = DEPTH_W'(trail_depth);
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at result %0d: %s", results_seen, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [DEPTH_W-1:0] got,
                               input logic [DEPTH_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_moves.size() == 0)
                report_mismatch("result item with no step item pending");
            else
            begin
                want = expected_moves.pop_front();
                check_field("status", DEPTH_W'(result_ch.status), DEPTH_W'(want.status));
                check_field("cell_row", DEPTH_W'(result_ch.cell_row), DEPTH_W'(want.cell_row));
                check_field("cell_col", DEPTH_W'(result_ch.cell_col), DEPTH_W'(want.cell_col));
                check_field("wall_row", DEPTH_W'(result_ch.wall_row), DEPTH_W'(want.wall_row));
                check_field("wall_col", DEPTH_W'(result_ch.wall_col), DEPTH_W'(want.wall_col));
                check_field("stack_depth", result_ch.stack_depth, want.stack_depth);
            end
            results_seen++;
        end
    end

    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic set_idle_phase(input int phase);
        case (phase % 4)
            0:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1:
            begin
                send_idle_pct  = 63;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 63;
            end
            default:
            begin
                send_idle_pct  = 30;
                recv_stall_pct = 30;
            end
        endcase
    endtask

    task automatic send_step(input dir_t d0, input dir_t d1, input dir_t d2, input dir_t d3);
        while ($urandom_range(99) < send_idle_pct)
        begin
            step_ch.valid <= 1'b0;
            @(posedge clk);
        end
        step_ch.valid      <= 1'b1;
        step_ch.try_first  <= d0;
        step_ch.try_second <= d1;
        step_ch.try_third  <= d2;
        step_ch.try_fourth <= d3;
        @(posedge clk);
        while (!step_ch.ready)
            @(posedge clk);
        expected_moves.push_back(carve_step(d0, d1, d2, d3));
    endtask

    // At the start cell only a full permutation is sent, so the walk does not end early.
    task automatic send_random_step();
        dir_t p [NUM_DIRS];
        dir_t t;
        int   i;
        int   j;
        if (trail_depth <= 1 || $urandom_range(99) < 80)
        begin
            p[0] = DIR_RIGHT;
            p[1] = DIR_LEFT;
            p[2] = DIR_UP;
            p[3] = DIR_DOWN;
            for (i = NUM_DIRS - 1; i > 0; i--)
            begin
                j = $urandom_range(i);
                t = p[i];
                p[i] = p[j];
                p[j] = t;
            end
        end
        else
        begin
            for (i = 0; i < NUM_DIRS; i++)
                p[i] = dir_t'($urandom_range(3));
        end
        send_step(p[0], p[1], p[2], p[3]);
    endtask

    task automatic test_directed_walk();
        set_idle_phase(0);
        send_step(DIR_UP, DIR_LEFT, DIR_UP, DIR_RIGHT);
        send_step(DIR_RIGHT, DIR_RIGHT, DIR_RIGHT, DIR_RIGHT);
        send_step(DIR_UP, DIR_UP, DIR_UP, DIR_UP);
        send_step(DIR_LEFT, DIR_UP, DIR_LEFT, DIR_DOWN);
        send_step(DIR_LEFT, DIR_LEFT, DIR_LEFT, DIR_LEFT);
        send_step(DIR_DOWN, DIR_RIGHT, DIR_LEFT, DIR_UP);
        send_step(DIR_LEFT, DIR_LEFT, DIR_LEFT, DIR_LEFT);
        send_step(DIR_DOWN, DIR_DOWN, DIR_DOWN, DIR_DOWN);
        send_step(DIR_DOWN, DIR_RIGHT, DIR_UP, DIR_LEFT);
        repeat (14)
            send_step(DIR_RIGHT, DIR_RIGHT, DIR_RIGHT, DIR_RIGHT);
        send_step(DIR_RIGHT, DIR_RIGHT, DIR_RIGHT, DIR_RIGHT);
        send_step(DIR_DOWN, DIR_DOWN, DIR_DOWN, DIR_DOWN);
    endtask

    task automatic test_random_walk();
        int n;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % PHASE_ITEMS == 0)
                set_idle_phase(n / PHASE_ITEMS);
            send_random_step();
        end
    endtask

    task automatic test_steps_after_finish();
        set_idle_phase(3);
        while (trail_depth != 0)
            send_random_step();
        send_step(DIR_RIGHT, DIR_RIGHT, DIR_RIGHT, DIR_RIGHT);
        send_step(DIR_DOWN, DIR_DOWN, DIR_DOWN, DIR_DOWN);
        send_step(DIR_LEFT, DIR_UP, DIR_DOWN, DIR_RIGHT);
    endtask

    initial
    begin
        rst_n              = 1'b0;
        step_ch.valid      = 1'b0;
        step_ch.try_first  = DIR_RIGHT;
        step_ch.try_second = DIR_RIGHT;
        step_ch.try_third  = DIR_RIGHT;
        step_ch.try_fourth = DIR_RIGHT;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        mismatches         = 0;
        results_seen       = 0;
        for (int i = 0; i < NCELLS; i++)
        begin
            seen_cell[i] = 1'b0;
            trail[i]     = 0;
        end
        seen_cell[0] = 1'b1;
        trail_depth  = 1;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_walk();
        test_random_walk();
        test_steps_after_finish();
        step_ch.valid <= 1'b0;

        while (expected_moves.size() != 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+sv
sv/dmc_pkg.sv
sv/dmc_in_if.sv
sv/dmc_out_if.sv
sv/dmc_visited.sv
sv/dfs_maze_carver_top.sv
test/tb_dfs_maze_carver_top.sv
